// ===== rtl/edpp_pkg.sv =====
// shared types and constants of the tag parser
package edpp_pkg;

  // default geometry of the tag string
  localparam int DigestChars     = 32;
  localparam int SuffixSpan      = 8;
  localparam int MaxSuffixDigits = 5;

  // characters that fill the high digest half
  localparam int HalfChars = 16;

  // register reset value and decimal saturation point
  localparam logic [15:0] PartLimitReset = 16'd10000;
  localparam logic [16:0] PartsSat       = 17'h10000;

  // where in the string a character stands
  typedef enum logic [1:0] {
    RGN_HIGH,
    RGN_LOW,
    RGN_SUFFIX,
    RGN_NONE
  } region_e;

  // length class of a string, known on its last character
  typedef enum logic [1:0] {
    LEN_BAD,
    LEN_EXACT,
    LEN_SUFFIX
  } len_e;

  // one classified character, passed from front to back
  typedef struct packed {
    region_e    region;
    logic       is_hex;
    logic       is_digit;
    logic       is_dash;
    logic [3:0] nibble;
    logic       last;
    len_e       len;
  } token_t;

endpackage

// ===== rtl/etag_digest_parts_parser_unit.sv =====
// top level of the multipart tag parser
//
// usage: a tag string enters one character per transaction on the input
// channel (char_code_i, is_last_i), qualified by in_valid_i and held off by
// in_stall_o. the character flagged is_last_i ends the string and yields one
// result transaction on the output channel (tag_ok_o, digest_high_o,
// digest_low_o, part_count_o), qualified by out_valid_o and held off by
// out_stall_i. other characters yield nothing.
// throughput: one character per cycle while in_stall_o is low; a front stage
// classifies each character and a back stage updates the accumulators,
// joined by a two-entry token queue; the result goes to an output register.
// the part limit is written through cfg_we_i / cfg_wdata_i; the user must
// do so only while idle, the block itself does not enforce it.
// reset clears the parse state and the queue and sets the part limit to 10000.
// while the receiver stalls, the result stays in the output register; the
// back stage keeps consuming characters of the next string and stops only at
// its last one, after which the queue fills and in_stall_o rises.
module etag_digest_parts_parser_unit #(
  parameter int DIGEST_CHARS      = edpp_pkg::DigestChars,
  parameter int SUFFIX_SPAN       = edpp_pkg::SuffixSpan,
  parameter int MAX_SUFFIX_DIGITS = edpp_pkg::MaxSuffixDigits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tag_ok_o,
  output logic [63:0] digest_high_o,
  output logic [63:0] digest_low_o,
  output logic [15:0] part_count_o
);

  logic             tok_push;
  logic             tok_full;
  logic             tok_valid;
  logic             tok_pop;
  edpp_pkg::token_t front_tok;
  edpp_pkg::token_t back_tok;

  // character classification
  edpp_front #(
    .DIGEST_CHARS (DIGEST_CHARS),
    .SUFFIX_SPAN  (SUFFIX_SPAN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .in_stall_o  (in_stall_o),
    .tok_full_i  (tok_full),
    .tok_valid_o (tok_push),
    .tok_o       (front_tok)
  );

  // token queue
  edpp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (tok_push),
    .push_tok_i (front_tok),
    .full_o     (tok_full),
    .valid_o    (tok_valid),
    .pop_tok_o  (back_tok),
    .pop_i      (tok_pop)
  );

  // accumulation and result
  edpp_back #(
    .MAX_SUFFIX_DIGITS (MAX_SUFFIX_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .tok_valid_i   (tok_valid),
    .tok_i         (back_tok),
    .tok_pop_o     (tok_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tag_ok_o      (tag_ok_o),
    .digest_high_o (digest_high_o),
    .digest_low_o  (digest_low_o),
    .part_count_o  (part_count_o)
  );

endmodule

// ===== rtl/edpp_front.sv =====
// front end: accepts characters, tracks position and classifies them
module edpp_front #(
  parameter int DIGEST_CHARS = edpp_pkg::DigestChars,
  parameter int SUFFIX_SPAN  = edpp_pkg::SuffixSpan
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        char_code_i,
  input  logic              is_last_i,
  output logic              in_stall_o,
  input  logic              tok_full_i,
  output logic              tok_valid_o,
  output edpp_pkg::token_t  tok_o
);

  localparam int TagLen = DIGEST_CHARS + SUFFIX_SPAN;
  localparam int IdxW   = $clog2(TagLen + 2);

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] LowBias = 8'h57;
  localparam logic [7:0] UpBias  = 8'h37;

  logic            accept;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW:0]   len;
  logic [7:0]      diff;
  logic            is_num;
  logic            is_lhex;
  logic            is_uhex;

  assign accept      = in_valid_i && !tok_full_i;
  assign in_stall_o  = tok_full_i;
  assign tok_valid_o = accept;

  // character position, saturating past the longest legal string
  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      if (is_last_i) begin
        idx_d = '0;
      end else if (idx_q <= IdxW'(TagLen)) begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // character classes
  always_comb begin
    is_num  = (char_code_i >= ChZero) && (char_code_i <= ChNine);
    is_lhex = (char_code_i >= ChLowA) && (char_code_i <= ChLowF);
    is_uhex = (char_code_i >= ChUpA) && (char_code_i <= ChUpF);
    if (is_lhex) begin
      diff = char_code_i - LowBias;
    end else if (is_uhex) begin
      diff = char_code_i - UpBias;
    end else begin
      diff = char_code_i - ChZero;
    end
  end

  assign len = (IdxW + 1)'(idx_q) + (IdxW + 1)'(1);

  // token fields
  always_comb begin
    tok_o.is_hex   = is_num || is_lhex || is_uhex;
    tok_o.is_digit = is_num;
    tok_o.is_dash  = (char_code_i == ChDash);
    tok_o.nibble   = diff[3:0];
    tok_o.last     = is_last_i;
    if (idx_q < IdxW'(edpp_pkg::HalfChars)) begin
      tok_o.region = edpp_pkg::RGN_HIGH;
    end else if (idx_q < IdxW'(DIGEST_CHARS)) begin
      tok_o.region = edpp_pkg::RGN_LOW;
    end else if (idx_q < IdxW'(TagLen)) begin
      tok_o.region = edpp_pkg::RGN_SUFFIX;
    end else begin
      tok_o.region = edpp_pkg::RGN_NONE;
    end
    if (len < (IdxW + 1)'(DIGEST_CHARS) || len > (IdxW + 1)'(TagLen)) begin
      tok_o.len = edpp_pkg::LEN_BAD;
    end else if (len == (IdxW + 1)'(DIGEST_CHARS)) begin
      tok_o.len = edpp_pkg::LEN_EXACT;
    end else begin
      tok_o.len = edpp_pkg::LEN_SUFFIX;
    end
  end

endmodule

// ===== rtl/edpp_fifo.sv =====
// two-entry token queue between front and back
module edpp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  edpp_pkg::token_t  push_tok_i,
  output logic              full_o,
  output logic              valid_o,
  output edpp_pkg::token_t  pop_tok_o,
  input  logic              pop_i
);

  localparam int Depth = 2;

  edpp_pkg::token_t mem_q [Depth];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o    = (count_q == 2'(Depth));
  assign valid_o   = (count_q != 2'd0);
  assign pop_tok_o = mem_q[rptr_q];

  // pointer and fill count
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // token storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_tok_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'(Depth))
    else $error("token queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("token popped from empty queue");

endmodule

// ===== rtl/edpp_back.sv =====
// back end: accumulates digest and part count, forms the result
module edpp_back #(
  parameter int MAX_SUFFIX_DIGITS = edpp_pkg::MaxSuffixDigits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              tok_valid_i,
  input  edpp_pkg::token_t  tok_i,
  output logic              tok_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              tag_ok_o,
  output logic [63:0]       digest_high_o,
  output logic [63:0]       digest_low_o,
  output logic [15:0]       part_count_o
);

  localparam int DigW = $clog2(MAX_SUFFIX_DIGITS + 2);

  logic [15:0]     limit_q;
  logic [63:0]     high_q, high_d;
  logic [63:0]     low_q, low_d;
  logic            hbad_q, hbad_d;
  logic            dash_q, dash_d;
  logic [DigW-1:0] digits_q, digits_d;
  logic [16:0]     parts_q, parts_d;
  logic            sbad_q, sbad_d;
  logic [20:0]     times_ten;
  logic            ok;
  logic            load;

  logic            out_valid_q;
  logic            tag_ok_q;
  logic [63:0]     out_high_q;
  logic [63:0]     out_low_q;
  logic [15:0]     out_parts_q;

  // a last token needs a free output register
  assign tok_pop_o = tok_valid_i && (!tok_i.last || !out_valid_q || !out_stall_i);
  assign load      = tok_pop_o && tok_i.last;

  assign times_ten = {1'b0, parts_q, 3'b000} + {3'b000, parts_q, 1'b0}
                   + 21'(tok_i.nibble);

  // per-character update of the parse state
  always_comb begin
    high_d   = high_q;
    low_d    = low_q;
    hbad_d   = hbad_q;
    dash_d   = dash_q;
    digits_d = digits_q;
    parts_d  = parts_q;
    sbad_d   = sbad_q;
    case (tok_i.region)
      edpp_pkg::RGN_HIGH: begin
        if (!tok_i.is_hex) begin
          hbad_d = 1'b1;
        end else begin
          high_d = {high_q[59:0], tok_i.nibble};
        end
      end
      edpp_pkg::RGN_LOW: begin
        if (!tok_i.is_hex) begin
          hbad_d = 1'b1;
        end else begin
          low_d = {low_q[59:0], tok_i.nibble};
        end
      end
      edpp_pkg::RGN_SUFFIX: begin
        if (!dash_q) begin
          if (tok_i.is_dash) begin
            dash_d = 1'b1;
          end
        end else if (tok_i.is_digit) begin
          if (digits_q <= DigW'(MAX_SUFFIX_DIGITS)) begin
            digits_d = digits_q + DigW'(1);
          end
          if (times_ten > 21'(edpp_pkg::PartsSat)) begin
            parts_d = edpp_pkg::PartsSat;
          end else begin
            parts_d = times_ten[16:0];
          end
        end else begin
          sbad_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // verdict on the last character
  always_comb begin
    ok = 1'b0;
    if (tok_i.len != edpp_pkg::LEN_BAD && !hbad_d) begin
      if (tok_i.len == edpp_pkg::LEN_EXACT) begin
        ok = 1'b1;
      end else if (dash_d && !sbad_d && digits_d <= DigW'(MAX_SUFFIX_DIGITS)
                   && parts_d <= {1'b0, limit_q}) begin
        ok = 1'b1;
      end
    end
  end

  // parse state, cleared after every result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q   <= '0;
      low_q    <= '0;
      hbad_q   <= 1'b0;
      dash_q   <= 1'b0;
      digits_q <= '0;
      parts_q  <= '0;
      sbad_q   <= 1'b0;
    end else if (tok_pop_o) begin
      if (tok_i.last) begin
        high_q   <= '0;
        low_q    <= '0;
        hbad_q   <= 1'b0;
        dash_q   <= 1'b0;
        digits_q <= '0;
        parts_q  <= '0;
        sbad_q   <= 1'b0;
      end else begin
        high_q   <= high_d;
        low_q    <= low_d;
        hbad_q   <= hbad_d;
        dash_q   <= dash_d;
        digits_q <= digits_d;
        parts_q  <= parts_d;
        sbad_q   <= sbad_d;
      end
    end
  end

  // part limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= edpp_pkg::PartLimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      tag_ok_q    <= ok;
      out_high_q  <= ok ? high_d : 64'd0;
      out_low_q   <= ok ? low_d : 64'd0;
      out_parts_q <= ok ? parts_d[15:0] : 16'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tag_ok_o      = tag_ok_q;
  assign digest_high_o = out_high_q;
  assign digest_low_o  = out_low_q;
  assign part_count_o  = out_parts_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) load |=> out_valid_q)
    else $error("result not presented after last character");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   load |=> (parts_q == 17'd0 && !dash_q && !hbad_q && !sbad_q))
    else $error("parse state not cleared after result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !tag_ok_q) |->
                   (out_high_q == 64'd0 && out_low_q == 64'd0 && out_parts_q == 16'd0))
    else $error("rejected tag carries nonzero payload");

endmodule

// ===== test/tb.sv =====
// self-checking bench for the tag parser: queued characters, character-level predictor, result check
module tb;

  // string geometry, taken from the package defaults
  localparam int unsigned TagMax     = edpp_pkg::DigestChars + edpp_pkg::SuffixSpan;
  localparam int          HoldCycles = 400;
  localparam int          ReportMax  = 10;

  // character codes the parser reacts to
  localparam logic [7:0] ChDash = 8'h2D;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpF  = 8'h46;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowF = 8'h66;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } tag_char_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] digest_hi;
    logic [63:0] digest_lo;
    logic [15:0] parts;
  } tag_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i = '0;
  logic        is_last_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        tag_ok_o;
  logic [63:0] digest_high_o;
  logic [63:0] digest_low_o;
  logic [15:0] part_count_o;

  etag_digest_parts_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tag_ok_o      (tag_ok_o),
    .digest_high_o (digest_high_o),
    .digest_low_o  (digest_low_o),
    .part_count_o  (part_count_o)
  );

  always #1 clk_i = ~clk_i;

  // stimulus and expectations
  tag_char_t   char_q[$];
  tag_result_t tag_results_q[$];
  logic [7:0]  tag_buf[$];
  string       hex_set = "0123456789abcdefABCDEF";

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors        = 0;
  int results_seen  = 0;
  int hold_at       = -1;
  int hold_taken    = -1;
  int hold_left     = 0;

  // predictor state: register copy and parse progress
  logic [15:0] tp_limit = edpp_pkg::PartLimitReset;
  int unsigned tp_index;
  logic [63:0] tp_high;
  logic [63:0] tp_low;
  logic        tp_hex_bad;
  logic        tp_dash;
  int unsigned tp_digits;
  int unsigned tp_parts;
  logic        tp_sfx_bad;

  task automatic clear_tag_state();
    tp_index   = 0;
    tp_high    = '0;
    tp_low     = '0;
    tp_hex_bad = 1'b0;
    tp_dash    = 1'b0;
    tp_digits  = 0;
    tp_parts   = 0;
    tp_sfx_bad = 1'b0;
  endtask

  initial clear_tag_state();

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return {1'b0, 4'(c - ChZero)};
    if (c >= ChLowA && c <= ChLowF) return {1'b0, 4'(c - ChLowA + 8'd10)};
    if (c >= ChUpA && c <= ChUpF) return {1'b0, 4'(c - ChUpA + 8'd10)};
    return 5'h10;
  endfunction

  // one accepted character; on the last one the expected result is queued
  task automatic parse_tag_char(input logic [7:0] code, input logic last);
    int unsigned pos;
    logic [4:0]  nib;
    tag_result_t res;
    pos = tp_index;
    if (pos < edpp_pkg::DigestChars) begin
      nib = hex_nibble(code);
      if (nib[4]) begin
        tp_hex_bad = 1'b1;
      end else if (pos < edpp_pkg::HalfChars) begin
        tp_high = {tp_high[59:0], nib[3:0]};
      end else begin
        tp_low = {tp_low[59:0], nib[3:0]};
      end
    end else if (pos < TagMax) begin
      if (!tp_dash) begin
        if (code == ChDash) tp_dash = 1'b1;
      end else if (code >= ChZero && code <= ChNine) begin
        if (tp_digits <= edpp_pkg::MaxSuffixDigits) tp_digits++;
        tp_parts = tp_parts * 10 + (code - ChZero);
        if (tp_parts > edpp_pkg::PartsSat) tp_parts = edpp_pkg::PartsSat;
      end else begin
        tp_sfx_bad = 1'b1;
      end
    end
    if (pos <= TagMax) tp_index = pos + 1;
    if (last) begin
      res = '0;
      if (pos + 1 >= edpp_pkg::DigestChars && pos + 1 <= TagMax && !tp_hex_bad) begin
        if (pos + 1 == edpp_pkg::DigestChars) begin
          res.ok = 1'b1;
        end else if (tp_dash && !tp_sfx_bad && tp_digits <= edpp_pkg::MaxSuffixDigits &&
                     tp_parts <= tp_limit) begin
          res.ok    = 1'b1;
          res.parts = tp_parts[15:0];
        end
      end
      if (res.ok) begin
        res.digest_hi = tp_high;
        res.digest_lo = tp_low;
      end
      tag_results_q = {tag_results_q, res};
      clear_tag_state();
    end
  endtask

  // sender: holds a stalled transaction, otherwise offers the next character
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) parse_tag_char(char_code_i, is_last_i);
      if (!in_valid_i || !in_stall_o) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i  <= 1'b1;
          char_code_i <= char_q[0].code;
          is_last_i   <= char_q[0].last;
          char_q.delete(0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic log_fault(input string text);
    errors++;
    if (errors <= ReportMax) $display("%0t: %s", $time, text);
  endtask

  // receiver: checks each result transaction and drives the stall
  always @(posedge clk_i) begin : result_watch
    tag_result_t want;
    tag_result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        got = {tag_ok_o, digest_high_o, digest_low_o, part_count_o};
        if (tag_results_q.size() == 0) begin
          log_fault($sformatf("result with none expected: ok=%0d hi=%h lo=%h parts=%0d",
                              got.ok, got.digest_hi, got.digest_lo, got.parts));
        end else begin
          want = tag_results_q.pop_front();
          if (got !== want)
            log_fault($sformatf({"result mismatch: expected ok=%0d hi=%h lo=%h parts=%0d,",
                                 " got ok=%0d hi=%h lo=%h parts=%0d"},
                                want.ok, want.digest_hi, want.digest_lo, want.parts,
                                got.ok, got.digest_hi, got.digest_lo, got.parts));
        end
      end
      // long hold-off lets the block fill up and stall its input
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_at >= 0 && hold_at != hold_taken && results_seen >= hold_at) begin
        hold_taken = hold_at;
        hold_left  = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // string building
  task automatic queue_tag();
    tag_char_t item;
    for (int k = 0; k < tag_buf.size(); k++) begin
      item.code = tag_buf[k];
      item.last = (k == tag_buf.size() - 1);
      char_q = {char_q, item};
    end
  endtask

  task automatic queue_text(input string s);
    logic [7:0] c;
    tag_buf.delete();
    for (int k = 0; k < s.len(); k++) begin
      c = s[k];
      tag_buf = {tag_buf, c};
    end
    queue_tag();
  endtask

  task automatic add_hex(input int n);
    logic [7:0] c;
    for (int k = 0; k < n; k++) begin
      c = hex_set[$urandom_range(21)];
      tag_buf = {tag_buf, c};
    end
  endtask

  task automatic add_filler(input int n);
    logic [7:0] c;
    for (int k = 0; k < n; k++) begin
      do c = 8'($urandom_range(255)); while (c == ChDash);
      tag_buf = {tag_buf, c};
    end
  endtask

  // nd decimal digits of v, with leading zeros, high digit first
  task automatic add_digits(input int unsigned v, input int nd);
    logic [7:0]  dig[$];
    logic [7:0]  c;
    int unsigned rest;
    rest = v;
    for (int k = 0; k < nd; k++) begin
      c = ChZero + 8'(rest % 10);
      dig.push_front(c);
      rest /= 10;
    end
    for (int k = 0; k < nd; k++) tag_buf = {tag_buf, dig[k]};
  endtask

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] nib;
    do begin
      c   = 8'($urandom_range(255));
      nib = hex_nibble(c);
    end while (!nib[4]);
    return c;
  endfunction

  // part counts cluster around the limit and the saturation point
  function automatic int unsigned pick_count();
    case ($urandom_range(7))
      0:       return tp_limit;
      1:       return tp_limit + 1;
      2:       return (tp_limit == 0) ? 0 : tp_limit - 1;
      3:       return 65535 + $urandom_range(1);
      4:       return 99999;
      5:       return 0;
      6:       return $urandom_range(99);
      default: return $urandom_range(99999);
    endcase
  endfunction

  task automatic build_random_tag();
    int          kind;
    int          nd;
    int          nf;
    int unsigned v;
    logic [7:0]  c;
    kind = $urandom_range(99);
    tag_buf.delete();
    if (kind < 60) begin
      // well-formed tag with random content
      add_hex(edpp_pkg::DigestChars);
      if ($urandom_range(5) != 0) begin
        if ($urandom_range(9) == 0) begin
          nd = 0;
        end else begin
          v  = pick_count();
          nd = (v > 9999) ? 5 : (v > 999) ? 4 : (v > 99) ? 3 : (v > 9) ? 2 : 1;
          nd = $urandom_range(edpp_pkg::MaxSuffixDigits, nd);
        end
        nf = $urandom_range(edpp_pkg::SuffixSpan - 1 - nd, 0);
        add_filler(nf);
        tag_buf = {tag_buf, ChDash};
        if (nd != 0) add_digits(v, nd);
      end
    end else if (kind < 65) begin
      // too short
      add_hex($urandom_range(edpp_pkg::DigestChars - 1, 1));
    end else if (kind < 70) begin
      // too long
      add_hex(edpp_pkg::DigestChars);
      tag_buf = {tag_buf, ChDash};
      add_digits($urandom_range(999), $urandom_range(3, 1));
      nf = $urandom_range(TagMax + 10, TagMax + 1) - tag_buf.size();
      if ($urandom_range(1)) add_digits($urandom_range(99999), nf);
      else add_filler(nf);
    end else if (kind < 75) begin
      // bad digest character
      add_hex(edpp_pkg::DigestChars);
      if ($urandom_range(1)) begin
        tag_buf = {tag_buf, ChDash};
        add_digits($urandom_range(9), 1);
      end
      tag_buf[$urandom_range(edpp_pkg::DigestChars - 1)] = non_hex_char();
    end else if (kind < 80) begin
      // no dash after the digest
      add_hex(edpp_pkg::DigestChars);
      add_filler($urandom_range(edpp_pkg::SuffixSpan, 1));
    end else if (kind < 85) begin
      // second dash or stray character in the suffix
      add_hex(edpp_pkg::DigestChars);
      tag_buf = {tag_buf, ChDash};
      add_digits($urandom_range(99), $urandom_range(2, 0));
      if ($urandom_range(1)) begin
        c = ChDash;
      end else begin
        do c = 8'($urandom_range(255)); while (c >= ChZero && c <= ChNine);
      end
      tag_buf = {tag_buf, c};
      add_digits($urandom_range(99), $urandom_range(2, 0));
    end else if (kind < 90) begin
      // more digits than allowed
      add_hex(edpp_pkg::DigestChars);
      tag_buf = {tag_buf, ChDash};
      add_digits($urandom_range(99999),
                 $urandom_range(edpp_pkg::SuffixSpan - 1, edpp_pkg::MaxSuffixDigits + 1));
    end else begin
      // raw noise
      nf = $urandom_range(TagMax + 8, 1);
      for (int k = 0; k < nf; k++) begin
        c = 8'($urandom_range(255));
        tag_buf = {tag_buf, c};
      end
    end
  endtask

  task automatic queue_random(input int chars);
    int n;
    n = 0;
    while (n < chars) begin
      build_random_tag();
      n += tag_buf.size();
      queue_tag();
    end
  endtask

  task automatic queue_directed();
    string hm;
    hm = "0123456789abcdefABCDEF9876543210";
    queue_text("00000000000000000000000000000000");
    queue_text("ffffffffffffffffffffffffffffffff");
    queue_text({"FFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFF", "-"});
    queue_text({hm, "-1"});
    queue_text({hm, "-10000"});
    queue_text({hm, "-10001"});
    queue_text({hm, "-65536"});
    queue_text({hm, "-99999"});
    queue_text({hm, "-00000"});
    queue_text({hm, "xyz-42"});
    queue_text({hm, "abc-1234"});
    queue_text({hm, "abc"});
    queue_text({hm, "-1-2"});
    queue_text({hm, "--"});
    queue_text({hm, "-000001"});
    queue_text({hm, "-12a"});
    queue_text("0123456789abcdefABCDEF987654321");
    queue_text("7");
    queue_text({hm, "-123456789"});
    queue_text({hm, "-12345678901234567890123456"});
    queue_text("g123456789abcdefABCDEF9876543210");
    queue_text("0123456789abcdefABCDEF987654321G-3");
    queue_text("0123456789abcdef/:@`GFabcdefabcd");
    queue_text({"00000000000000000000000000000000", "-0"});
  endtask

  // wait until every character is taken and every result has arrived
  task automatic wait_drained();
    while (char_q.size() != 0 || in_valid_i || tag_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_part_limit(input logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tp_limit = v;
  endtask

  task automatic start_phase(input int send_pct, input int recv_pct, input int chars);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    hold_at       = results_seen + 1;
    queue_random(chars);
  endtask

  // phase sequence: directed strings, then random traffic under several limits
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 32;
    recv_idle_pct = 72;
    queue_directed();
    wait_drained();

    write_part_limit(16'd0);
    start_phase(32, 72, 150);
    wait_drained();

    write_part_limit(16'hFFFF);
    start_phase(72, 32, 150);
    wait_drained();

    write_part_limit(16'($urandom_range(65534, 1)));
    start_phase(0, 0, 150);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
